@@ design/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the byte histogram block.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

@@ design/ccm_pkg.sv @@
// Types and constants for the byte class counter and mode finder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ccm_pkg;

  localparam int unsigned NUM_SYMS   = 256;
  localparam int unsigned OUT_W      = 9;

  localparam logic [7:0] CH_END      = 8'd0;
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] DIGIT_LO    = 8'd48;
  localparam logic [7:0] DIGIT_HI    = 8'd57;
  localparam logic [7:0] UPPER_LO    = 8'd65;
  localparam logic [7:0] UPPER_HI    = 8'd90;
  localparam logic [7:0] LOWER_LO    = 8'd97;
  localparam logic [7:0] LOWER_HI    = 8'd122;

  typedef struct packed {
    logic digit;
    logic lower;
    logic upper;
    logic other;
    logic white;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t k;
    k       = '0;
    k.digit = (c >= DIGIT_LO) && (c <= DIGIT_HI);
    k.lower = (c >= LOWER_LO) && (c <= LOWER_HI);
    k.upper = (c >= UPPER_LO) && (c <= UPPER_HI);
    k.other = !(k.digit || k.lower || k.upper);
    k.white = (c == CH_SPACE) || (c == CH_TAB);
    return k;
  endfunction

endpackage

`default_nettype wire

@@ design/ccm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ccm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/char_class_count_and_mode_core.sv @@
// Top level of the byte class counter and mode finder.
// Depends on ccm_pkg, ccm_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Takes one message byte per cycle unless stalled; a zero byte ends the message.
// Each byte's tally entry is read from a 256-entry RAM at accept and written
// back the next cycle, with the previous write forwarded when the same byte
// repeats, so the RAM port pair sets the one-byte-per-cycle rate. The result
// is loaded into an output register when the terminator leaves stage 1, and
// waits there; input is stalled only while a second terminator reaches a
// result register that is still full and stalled. Per-symbol seen flags sit
// in flip-flops and all clear at once on reset or when a terminator fires,
// so there is no clearing pass after reset or between messages. Bytes past
// MAX_LEN are dropped; counts above 511 saturate on output.
module char_class_count_and_mode_core #(
  parameter int unsigned MAX_LEN = 280
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_code,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [8:0]      out_whitespace_total,
  output logic [8:0]      out_digit_total,
  output logic [8:0]      out_lower_total,
  output logic [8:0]      out_upper_total,
  output logic [8:0]      out_other_total,
  output logic [7:0]      out_top_symbol,
  output logic [8:0]      out_top_count,
  output logic [8:0]      out_message_length
);

  import ccm_pkg::*;

  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned SW = (CW > OUT_W) ? CW : OUT_W;

  function automatic logic [OUT_W-1:0] sat_out(input logic [CW-1:0] v);
    logic [SW-1:0] w;
    w = SW'(v);
    return (w > SW'(511)) ? 9'd511 : w[OUT_W-1:0];
  endfunction

  // stage 1 holds the byte whose RAM read is in flight
  logic             s1_valid_r;
  logic [7:0]       s1_char_r;
  logic             s1_term;
  logic             s1_hold;
  logic             s1_fire;
  logic             accept;

  logic [NUM_SYMS-1:0] seen_r, seen_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       cnt_white_r, cnt_digit_r, cnt_lower_r, cnt_upper_r, cnt_other_r;
  logic [CW-1:0]       cnt_white_nxt, cnt_digit_nxt, cnt_lower_nxt, cnt_upper_nxt;
  logic [CW-1:0]       cnt_other_nxt;
  logic [7:0]          best_sym_r, best_sym_nxt;
  logic [CW-1:0]       best_tally_r, best_tally_nxt;
  logic [CW-1:0]       best_first_r, best_first_nxt;

  // last RAM write, for a read that raced it
  logic                fwd_valid_r;
  logic [7:0]          fwd_addr_r;
  logic [2*CW-1:0]     fwd_data_r;

  logic                wr_en;
  logic [2*CW-1:0]     wr_data;
  logic [2*CW-1:0]     rd_data;
  logic [2*CW-1:0]     cur_data;
  logic [CW-1:0]       cur_tally, cur_first, new_tally, new_first;
  logic                cur_seen;
  logic                take;
  char_class_t         cls;

  logic                out_valid_r;
  logic [8:0]          o_white_r, o_digit_r, o_lower_r, o_upper_r, o_other_r;
  logic [7:0]          o_sym_r;
  logic [8:0]          o_count_r, o_len_r;

  assign s1_term  = (s1_char_r == CH_END);
  assign s1_hold  = s1_valid_r && s1_term && out_valid_r && out_stall;
  assign s1_fire  = s1_valid_r && !s1_hold;
  assign in_stall = s1_hold;
  assign accept   = in_valid && !in_stall;

  ccm_ram #(
    .WIDTH (2 * CW),
    .DEPTH (NUM_SYMS)
  ) u_tally_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_char_r),
    .wdata (wr_data),
    .re    (accept),
    .raddr (in_char_code),
    .rdata (rd_data)
  );

  always_comb begin
    cls       = classify(s1_char_r);
    cur_seen  = seen_r[s1_char_r];
    cur_data  = (fwd_valid_r && (fwd_addr_r == s1_char_r)) ? fwd_data_r : rd_data;
    cur_tally = cur_data[2*CW-1:CW];
    cur_first = cur_data[CW-1:0];
    new_tally = (cur_seen ? cur_tally : '0) + CW'(1);
    new_first = cur_seen ? cur_first : pos_r;
    wr_en     = s1_fire && !s1_term && (pos_r < CW'(MAX_LEN));
    wr_data   = {new_tally, new_first};
    take      = (new_tally > best_tally_r) ||
                ((new_tally == best_tally_r) && (new_first < best_first_r));

    seen_nxt       = seen_r;
    pos_nxt        = pos_r;
    cnt_white_nxt  = cnt_white_r;
    cnt_digit_nxt  = cnt_digit_r;
    cnt_lower_nxt  = cnt_lower_r;
    cnt_upper_nxt  = cnt_upper_r;
    cnt_other_nxt  = cnt_other_r;
    best_sym_nxt   = best_sym_r;
    best_tally_nxt = best_tally_r;
    best_first_nxt = best_first_r;

    if (s1_fire && s1_term) begin
      seen_nxt       = '0;
      pos_nxt        = '0;
      cnt_white_nxt  = '0;
      cnt_digit_nxt  = '0;
      cnt_lower_nxt  = '0;
      cnt_upper_nxt  = '0;
      cnt_other_nxt  = '0;
      best_sym_nxt   = '0;
      best_tally_nxt = '0;
      best_first_nxt = '0;
    end else if (wr_en) begin
      seen_nxt[s1_char_r] = 1'b1;
      pos_nxt = pos_r + CW'(1);
      if (cls.digit) cnt_digit_nxt = cnt_digit_r + CW'(1);
      if (cls.lower) cnt_lower_nxt = cnt_lower_r + CW'(1);
      if (cls.upper) cnt_upper_nxt = cnt_upper_r + CW'(1);
      if (cls.other) cnt_other_nxt = cnt_other_r + CW'(1);
      if (cls.white) cnt_white_nxt = cnt_white_r + CW'(1);
      if (take) begin
        best_sym_nxt   = s1_char_r;
        best_tally_nxt = new_tally;
        best_first_nxt = new_first;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      seen_r       <= '0;
      pos_r        <= '0;
      cnt_white_r  <= '0;
      cnt_digit_r  <= '0;
      cnt_lower_r  <= '0;
      cnt_upper_r  <= '0;
      cnt_other_r  <= '0;
      best_sym_r   <= '0;
      best_tally_r <= '0;
      best_first_r <= '0;
      fwd_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (!s1_hold) begin
        s1_valid_r <= accept;
      end
      seen_r       <= seen_nxt;
      pos_r        <= pos_nxt;
      cnt_white_r  <= cnt_white_nxt;
      cnt_digit_r  <= cnt_digit_nxt;
      cnt_lower_r  <= cnt_lower_nxt;
      cnt_upper_r  <= cnt_upper_nxt;
      cnt_other_r  <= cnt_other_nxt;
      best_sym_r   <= best_sym_nxt;
      best_tally_r <= best_tally_nxt;
      best_first_r <= best_first_nxt;
      fwd_valid_r  <= wr_en;
      if (s1_fire && s1_term) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_char_r <= in_char_code;
    end
    if (wr_en) begin
      fwd_addr_r <= s1_char_r;
      fwd_data_r <= wr_data;
    end
    if (s1_fire && s1_term) begin
      o_white_r <= sat_out(cnt_white_r);
      o_digit_r <= sat_out(cnt_digit_r);
      o_lower_r <= sat_out(cnt_lower_r);
      o_upper_r <= sat_out(cnt_upper_r);
      o_other_r <= sat_out(cnt_other_r);
      o_sym_r   <= best_sym_r;
      o_count_r <= sat_out(best_tally_r);
      o_len_r   <= sat_out(pos_r);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_whitespace_total = o_white_r;
  assign out_digit_total      = o_digit_r;
  assign out_lower_total      = o_lower_r;
  assign out_upper_total      = o_upper_r;
  assign out_other_total      = o_other_r;
  assign out_top_symbol       = o_sym_r;
  assign out_top_count        = o_count_r;
  assign out_message_length   = o_len_r;

  `ASSERT_NEXT(a_seen_cleared, clk, rst_n, s1_fire && s1_term, seen_r == '0)
  `ASSERT_NEXT(a_result_posted, clk, rst_n, s1_fire && s1_term, out_valid_r)
  `ASSERT_IMPLIES(a_best_bound, clk, rst_n, 1'b1, best_tally_r <= pos_r)

endmodule

`default_nettype wire
